### sv/rgsw_pkg.sv
// Package for the RGB grayscale / sepia window filter.
// Types, register map, status codes and fixed-point constants; no dependencies.

package rgsw_pkg;

	// Frame side limit: pixels at or past this column or row are never filtered
	localparam int unsigned MAX_SIDE = 4096;
	localparam int unsigned SIDE_W   = 17;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned WIN_W   = 13;
	localparam int unsigned PROD_W  = 18;   // 8 bit channel times 10 bit coefficient
	localparam int unsigned ACC_W   = 19;   // sum of three products
	localparam int unsigned GSUM_W  = 10;   // r + g + b + 1

	// Sepia matrix in thousandths, one row per output channel (red, green, blue)
	localparam logic [9:0] SEPIA_K [3][3] = '{
		'{10'd393, 10'd769, 10'd189},
		'{10'd349, 10'd686, 10'd168},
		'{10'd272, 10'd534, 10'd131}
	};

	localparam logic [9:0]  SEPIA_LIM_SCALE = 10'd1000;
	localparam logic [8:0]  SEPIA_ROUND     = 9'd500;

	// floor(x / 3) = (x * 683) >> 11, exact for x <= 766
	localparam logic [9:0]  DIV3_RECIP = 10'd683;
	localparam int unsigned DIV3_SHIFT = 11;

	// floor(v / 1000) = (v * 134218) >> 27, exact for v <= 255500
	localparam logic [17:0] DIV1000_RECIP = 18'd134218;
	localparam int unsigned DIV1000_SHIFT = 27;

	typedef enum logic [1:0] {
		ST_FILTERED   = 2'd0,
		ST_OUTSIDE    = 2'd1,
		ST_NOT_COLOUR = 2'd2,
		ST_NO_IMAGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_WIN_LEFT   = 3'd1,
		REG_WIN_TOP    = 3'd2,
		REG_WIN_RIGHT  = 3'd3,
		REG_WIN_BOTTOM = 3'd4,
		REG_MAX_VALUE  = 3'd5,
		REG_IS_COLOUR  = 3'd6,
		REG_IMAGE_PRES = 3'd7
	} reg_addr_t;

	localparam logic MODE_GRAY  = 1'b0;
	localparam logic MODE_SEPIA = 1'b1;

endpackage

### sv/rgb_gray_sepia_window_filter_top.sv
// RGB grayscale / sepia window filter, top level: APB register file and
// a three-stage pixel pipeline. Depends on rgsw_pkg.
//
//  channel   dir  handshake                       payload
//  s_*       in   s_tvalid / s_tready             col, row, red_in, green_in, blue_in
//  m_*       out  m_tvalid / m_tready             red_out, green_out, blue_out, status
//  apb       in   psel & penable & pwrite         mode, window, max_value, flags
//
// One pixel per clock over three register stages unless m_tready stalls; m_tvalid
// is the stage 3 valid bit. Stage 1 does the window test, the constant products
// and the channel sum, stage 2 sums and clamps the sepia terms and scales the sum
// by 1/3, stage 3 scales by 1/1000 and picks the result into the output register.
// Each stage holds when the one after it is full and stalled, so bubbles close up
// and nothing is dropped or repeated. arst_n resets valid and config registers.

module rgb_gray_sepia_window_filter_top
	import rgsw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // col[11:0], row[23:12], red_in, green_in, blue_in
	// pixel out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // red_out, green_out, blue_out, status[25:24], zeros
);

	// configuration registers
	logic              mode_q;
	logic [WIN_W-1:0]  win_left_q, win_top_q, win_right_q, win_bottom_q;
	logic [PIX_W-1:0]  max_value_q;
	logic              is_colour_q;
	logic              image_present_q;

	logic      cfg_wr;
	reg_addr_t cfg_addr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign cfg_addr = reg_addr_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_GRAY;
			win_left_q      <= '0;
			win_top_q       <= '0;
			win_right_q     <= WIN_W'(MAX_SIDE);
			win_bottom_q    <= WIN_W'(MAX_SIDE);
			max_value_q     <= 8'd255;
			is_colour_q     <= 1'b1;
			image_present_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_MODE:       mode_q          <= pwdata[0];
				REG_WIN_LEFT:   win_left_q      <= pwdata[WIN_W-1:0];
				REG_WIN_TOP:    win_top_q       <= pwdata[WIN_W-1:0];
				REG_WIN_RIGHT:  win_right_q     <= pwdata[WIN_W-1:0];
				REG_WIN_BOTTOM: win_bottom_q    <= pwdata[WIN_W-1:0];
				REG_MAX_VALUE:  max_value_q     <= pwdata[PIX_W-1:0];
				REG_IS_COLOUR:  is_colour_q     <= pwdata[0];
				REG_IMAGE_PRES: image_present_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_addr)
			REG_MODE:       prdata = {31'd0, mode_q};
			REG_WIN_LEFT:   prdata = {19'd0, win_left_q};
			REG_WIN_TOP:    prdata = {19'd0, win_top_q};
			REG_WIN_RIGHT:  prdata = {19'd0, win_right_q};
			REG_WIN_BOTTOM: prdata = {19'd0, win_bottom_q};
			REG_MAX_VALUE:  prdata = {24'd0, max_value_q};
			REG_IS_COLOUR:  prdata = {31'd0, is_colour_q};
			REG_IMAGE_PRES: prdata = {31'd0, image_present_q};
			default:        prdata = '0;
		endcase
	end

	// pipeline flow control
	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	assign en3      = !vld_s3 || m_tready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign s_tready = en1;

	// input unpack
	logic [COORD_W-1:0] in_col, in_row;
	logic [PIX_W-1:0]   in_px [3];

	assign in_col   = s_tdata[11:0];
	assign in_row   = s_tdata[23:12];
	assign in_px[0] = s_tdata[31:24];
	assign in_px[1] = s_tdata[39:32];
	assign in_px[2] = s_tdata[47:40];

	// stage 1: window test, status, products
	logic    in_win;
	status_t status_c;

	always_comb begin
		in_win = ({1'b0, in_col} >= win_left_q) && ({1'b0, in_col} < win_right_q) &&
		         ({1'b0, in_row} >= win_top_q)  && ({1'b0, in_row} < win_bottom_q) &&
		         (SIDE_W'(in_col) < SIDE_W'(MAX_SIDE)) &&
		         (SIDE_W'(in_row) < SIDE_W'(MAX_SIDE));
		if (!image_present_q)
			status_c = ST_NO_IMAGE;
		else if (!is_colour_q)
			status_c = ST_NOT_COLOUR;
		else if (!in_win)
			status_c = ST_OUTSIDE;
		else
			status_c = ST_FILTERED;
	end

	status_t           status_s1;
	logic              mode_s1;
	logic [PIX_W-1:0]  px_s1 [3];
	logic [PROD_W-1:0] prod_s1 [3][3];
	logic [GSUM_W-1:0] gsum_s1;
	logic [PROD_W-1:0] lim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en1)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			status_s1 <= status_c;
			mode_s1   <= mode_q;
			gsum_s1   <= GSUM_W'(in_px[0]) + GSUM_W'(in_px[1]) + GSUM_W'(in_px[2]) +
			             GSUM_W'(1);
			lim_s1    <= PROD_W'(max_value_q) * PROD_W'(SEPIA_LIM_SCALE);
			for (int i = 0; i < 3; i++) begin
				px_s1[i] <= in_px[i];
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= PROD_W'(in_px[j]) * PROD_W'(SEPIA_K[i][j]);
			end
		end
	end

	// stage 2: sepia sums with clamp and half-up bias, grayscale third
	logic [ACC_W-1:0]  acc_c [3];
	logic [PROD_W-1:0] clamp_c [3];
	logic [19:0]       gray_prod_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = ACC_W'(prod_s1[i][0]) + ACC_W'(prod_s1[i][1]) +
			           ACC_W'(prod_s1[i][2]);
			if (acc_c[i] > ACC_W'(lim_s1))
				clamp_c[i] = lim_s1 + PROD_W'(SEPIA_ROUND);
			else
				clamp_c[i] = acc_c[i][PROD_W-1:0] + PROD_W'(SEPIA_ROUND);
		end
		gray_prod_c = 20'(gsum_s1) * 20'(DIV3_RECIP);
	end

	status_t           status_s2;
	logic              mode_s2;
	logic [PIX_W-1:0]  px_s2 [3];
	logic [PROD_W-1:0] acc_s2 [3];
	logic [PIX_W-1:0]  gray_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en2)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			status_s2 <= status_s1;
			mode_s2   <= mode_s1;
			gray_s2   <= gray_prod_c[DIV3_SHIFT +: PIX_W];
			for (int i = 0; i < 3; i++) begin
				px_s2[i]  <= px_s1[i];
				acc_s2[i] <= clamp_c[i];
			end
		end
	end

	// stage 3: divide by 1000 and pick the output
	logic [2*PROD_W-1:0] q_prod_c [3];
	logic [PIX_W-1:0]    res_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_prod_c[i] = (2*PROD_W)'(acc_s2[i]) * (2*PROD_W)'(DIV1000_RECIP);
			if (status_s2 != ST_FILTERED)
				res_c[i] = px_s2[i];
			else if (mode_s2 == MODE_SEPIA)
				res_c[i] = q_prod_c[i][DIV1000_SHIFT +: PIX_W];
			else
				res_c[i] = gray_s2;
		end
	end

	status_t          status_s3;
	logic [PIX_W-1:0] res_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en3)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			status_s3 <= status_s2;
			for (int i = 0; i < 3; i++)
				res_s3[i] <= res_c[i];
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {6'd0, status_s3, res_s3[2], res_s3[1], res_s3[0]};

endmodule
